@@ rtl/core/rwr_pkg.sv @@
// Shared types and constants of the rectangular window reduction core.
// Used by rwr_cell, rwr_window and rect_window_reduce_core; no dependencies.
package rwr_pkg;

   // Reduction operator codes; the unused code acts as a sum
   localparam logic [1:0] OP_SUM = 2'd0;
   localparam logic [1:0] OP_MAX = 2'd1;
   localparam logic [1:0] OP_MIN = 2'd2;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_OP_MODE     = 2'd0,
      CSR_WIN_WIDTH   = 2'd1,
      CSR_WIN_HEIGHT  = 2'd2,
      CSR_LINE_WIDTH  = 2'd3
   } csr_idx_type;

   // Register field widths
   localparam int CSR_DATA_BITS = 12;
   localparam int OP_BITS       = 2;
   localparam int WIN_CFG_BITS  = 6;
   localparam int LINE_CFG_BITS = 12;

   // Row counter saturates at its all-ones value
   localparam int         ROW_BITS = 6;
   localparam logic [5:0] ROW_MAX  = 6'd63;

   // Defaults of the top-level parameters
   localparam int DEF_MAX_LINE   = 2048;
   localparam int DEF_MAX_WIN    = 32;
   localparam int DEF_PIXEL_BITS = 16;

   // Reset values of the registers
   localparam logic [1:0]  RST_OP_MODE    = OP_SUM;
   localparam logic [5:0]  RST_WIN_WIDTH  = 6'd3;
   localparam logic [5:0]  RST_WIN_HEIGHT = 6'd3;
   localparam logic [11:0] RST_LINE_WIDTH = 12'd640;

   // Control flags that travel with each word down the pipeline
   typedef struct packed {
      logic valid;
      logic emit;
      logic eol;
   } ctl_type;

endpackage

@@ rtl/core/rwr_cell.sv @@
// One cell of the vertical chain: a line delay memory plus one column combine step.
// Depends on rwr_pkg.
module rwr_cell
   import rwr_pkg::*;
#(
   parameter int MAX_LINE   = DEF_MAX_LINE,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   parameter int ACC_BITS   = 26,
   parameter int WIN_W      = 6,
   parameter int IDX        = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic [OP_BITS-1:0]                  op,
   input  logic [WIN_W-1:0]                    height,
   input  ctl_type                             ctl_in,
   input  logic [$clog2(MAX_LINE)-1:0]         col_in,
   input  logic [$clog2(MAX_LINE)-1:0]         ocol_in,
   input  logic signed [PIXEL_BITS-1:0]        d_in,
   input  logic signed [ACC_BITS-1:0]          p_in,
   output ctl_type                             ctl_out,
   output logic [$clog2(MAX_LINE)-1:0]         col_out,
   output logic [$clog2(MAX_LINE)-1:0]         ocol_out,
   output logic signed [PIXEL_BITS-1:0]        d_out,
   output logic signed [ACC_BITS-1:0]          p_out
);

   localparam int COL_W = $clog2(MAX_LINE);

   logic signed [PIXEL_BITS-1:0] line_mem [MAX_LINE];
   logic signed [PIXEL_BITS-1:0] d_ff;
   logic signed [ACC_BITS-1:0]   p_ff, p_in_c;
   ctl_type                      ctl_ff;
   logic [COL_W-1:0]             col_ff, ocol_ff;
   logic signed [ACC_BITS-1:0]   d_ext;
   logic                         take_row;

   function automatic logic signed [ACC_BITS-1:0] combine(
      input logic [OP_BITS-1:0] opc,
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b);
      case (opc)
         OP_MAX:  combine = (a > b) ? a : b;
         OP_MIN:  combine = (a < b) ? a : b;
         default: combine = a + b;
      endcase
   endfunction

   // The incoming data is the line IDX-1 rows above; fold it in while inside the window
   assign d_ext    = ACC_BITS'(d_in);
   assign take_row = (IDX > 1) && (32'(IDX - 1) < 32'(height));
   assign p_in_c   = take_row ? combine(op, p_in, d_ext) : p_in;

   // Read the older line and store the newer one at the same column
   always_ff @(posedge clock) begin
      if (en && ctl_in.valid) begin
         d_ff             <= line_mem[col_in];
         line_mem[col_in] <= d_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         col_ff  <= col_in;
         ocol_ff <= ocol_in;
         p_ff    <= p_in_c;
      end
   end

   // Advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign col_out  = col_ff;
   assign ocol_out = ocol_ff;
   assign d_out    = d_ff;
   assign p_out    = p_ff;

endmodule

@@ rtl/core/rwr_window.sv @@
// Horizontal stage: last column combine, column shift row and registered reduction tree.
// Depends on rwr_pkg.
module rwr_window
   import rwr_pkg::*;
#(
   parameter int MAX_WIN    = DEF_MAX_WIN,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   parameter int ACC_BITS   = 26,
   parameter int COL_W      = 11,
   parameter int WIN_W      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [OP_BITS-1:0]            op,
   input  logic [WIN_W-1:0]              width,
   input  logic [WIN_W-1:0]              height,
   input  ctl_type                       ctl_in,
   input  logic [COL_W-1:0]              ocol_in,
   input  logic signed [PIXEL_BITS-1:0]  d_in,
   input  logic signed [ACC_BITS-1:0]    p_in,
   output ctl_type                       ctl_out,
   output logic [COL_W-1:0]              ocol_out,
   output logic signed [ACC_BITS-1:0]    value_out
);

   localparam int LEVELS = $clog2(MAX_WIN);
   localparam int TREE_N = 1 << LEVELS;

   logic signed [ACC_BITS-1:0] colv_ff, colv_in;
   ctl_type                    fctl_ff, sctl_ff;
   logic [COL_W-1:0]           focol_ff, socol_ff;
   logic signed [ACC_BITS-1:0] cells_ff [TREE_N];
   logic signed [ACC_BITS-1:0] leaf [TREE_N];
   logic signed [ACC_BITS-1:0] tree_ff [LEVELS][TREE_N/2];
   ctl_type                    tctl_ff [LEVELS];
   logic [COL_W-1:0]           tocol_ff [LEVELS];
   logic signed [ACC_BITS-1:0] ident;

   function automatic logic signed [ACC_BITS-1:0] combine(
      input logic [OP_BITS-1:0] opc,
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b);
      case (opc)
         OP_MAX:  combine = (a > b) ? a : b;
         OP_MIN:  combine = (a < b) ? a : b;
         default: combine = a + b;
      endcase
   endfunction

   // Fold in the oldest stored line when the window reaches it
   always_comb begin
      if (32'(MAX_WIN - 1) < 32'(height)) begin
         colv_in = combine(op, p_in, ACC_BITS'(d_in));
      end else begin
         colv_in = p_in;
      end
   end

   // Neutral element of the operator for masked leaves
   always_comb begin
      case (op)
         OP_MAX:  ident = {1'b1, {(ACC_BITS-1){1'b0}}};
         OP_MIN:  ident = {1'b0, {(ACC_BITS-1){1'b1}}};
         default: ident = '0;
      endcase
   end

   // Mask columns beyond the window width
   always_comb begin
      for (int i = 0; i < TREE_N; i++) begin
         leaf[i] = (i < 32'(width)) ? cells_ff[i] : ident;
      end
   end

   // Payload: column value, shift row, tree levels
   always_ff @(posedge clock) begin
      if (en) begin
         colv_ff  <= colv_in;
         focol_ff <= ocol_in;
         socol_ff <= focol_ff;
         if (fctl_ff.valid) begin
            cells_ff[0] <= colv_ff;
            for (int i = 1; i < TREE_N; i++) begin
               cells_ff[i] <= cells_ff[i-1];
            end
         end
         for (int i = 0; i < TREE_N/2; i++) begin
            tree_ff[0][i] <= combine(op, leaf[2*i], leaf[2*i+1]);
         end
         tocol_ff[0] <= socol_ff;
         for (int l = 1; l < LEVELS; l++) begin
            for (int i = 0; i < TREE_N/2; i++) begin
               if (i < (TREE_N >> (l + 1))) begin
                  tree_ff[l][i] <= combine(op, tree_ff[l-1][2*i], tree_ff[l-1][2*i+1]);
               end
            end
            tocol_ff[l] <= tocol_ff[l-1];
         end
      end
   end

   // Control flags through the same stages
   always_ff @(posedge clock) begin
      if (reset) begin
         fctl_ff <= '0;
         sctl_ff <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            tctl_ff[l] <= '0;
         end
      end else if (en) begin
         fctl_ff    <= ctl_in;
         sctl_ff    <= fctl_ff;
         tctl_ff[0] <= sctl_ff;
         for (int l = 1; l < LEVELS; l++) begin
            tctl_ff[l] <= tctl_ff[l-1];
         end
      end
   end

   assign ctl_out   = tctl_ff[LEVELS-1];
   assign ocol_out  = tocol_ff[LEVELS-1];
   assign value_out = tree_ff[LEVELS-1][0];

endmodule

@@ rtl/core/rect_window_reduce_core.sv @@
// Top level of the rectangular window sum / maximum / minimum core.
// Depends on rwr_pkg, rwr_cell and rwr_window.
//
// Usage: pixels arrive in raster order on the req_ channel, one word per
// pixel, req_tuser high on the first pixel of a frame. Each source line is
// line_width pixels wide and already holds the window margins. Results leave
// on the rsp_ channel: one word for each pixel whose window of window_width
// by window_height lies fully inside the stream, rsp_tlast on the last result
// of a line. Registers are written through csr_ while the core is idle.
// Throughput: one pixel per clock while the receiver takes results. A pixel
// reaches rsp_tvalid through the front stage, the chain of MAX_WIN-1 line
// cells, one per stored line, the window stage with its reduction tree across
// the window columns, and the result register.
// Reset clears counters, pipeline flags and registers to their defaults; the
// line memories are not cleared. When the receiver stalls, the whole pipeline
// holds and req_tready drops until the waiting result word is taken.
module rect_window_reduce_core
   import rwr_pkg::*;
#(
   parameter int MAX_LINE   = DEF_MAX_LINE,
   parameter int MAX_WIN    = DEF_MAX_WIN,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0] req_tdata,  // [PIXEL_BITS-1:0] pixel
   input  logic                      req_tuser,            // start_of_frame
   // Result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // result_value [ACC-1:0], out_column above it, zero filled
   output logic [((PIXEL_BITS+2*$clog2(MAX_WIN)+$clog2(MAX_LINE)+7)/8)*8-1:0] rsp_tdata,
   output logic                      rsp_tlast,            // end_of_line
   // Configuration port
   input  logic                      csr_we,
   input  logic [1:0]                csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int ACC_BITS  = PIXEL_BITS + 2 * $clog2(MAX_WIN);
   localparam int COL_W     = $clog2(MAX_LINE);
   localparam int LEN_W     = $clog2(MAX_LINE + 1);
   localparam int WIN_W     = $clog2(MAX_WIN + 1);
   localparam int NCELL     = MAX_WIN - 1;
   localparam int OUT_BITS  = ((ACC_BITS + COL_W + 7) / 8) * 8;
   localparam int PAD_BITS  = OUT_BITS - ACC_BITS - COL_W;

   // Configuration registers
   logic [OP_BITS-1:0]       op_ff;
   logic [WIN_CFG_BITS-1:0]  wcfg_ff, hcfg_ff;
   logic [LINE_CFG_BITS-1:0] lcfg_ff;
   logic [WIN_W-1:0]         win_w, win_h;
   logic [LEN_W-1:0]         len;

   // Front counters and stage
   logic [COL_W-1:0]         col_ff, col_in, c_cur;
   logic [ROW_BITS-1:0]      row_ff, row_in, r_cur;
   ctl_type                  front_ctl_ff, front_ctl_in;
   logic [COL_W-1:0]         front_col_ff, front_ocol_ff, ocol_cur;
   logic signed [PIXEL_BITS-1:0] front_px_ff;
   logic [LEN_W-1:0]         c_next;
   logic                     pipe_en, accept;

   // Cell chain links
   ctl_type                      ch_ctl  [NCELL+1];
   logic [COL_W-1:0]             ch_col  [NCELL+1];
   logic [COL_W-1:0]             ch_ocol [NCELL+1];
   logic signed [PIXEL_BITS-1:0] ch_d    [NCELL+1];
   logic signed [ACC_BITS-1:0]   ch_p    [NCELL+1];

   // Window output and result register
   ctl_type                    win_ctl;
   logic [COL_W-1:0]           win_ocol;
   logic signed [ACC_BITS-1:0] win_value;
   logic                       rsp_valid_ff, rsp_last_ff;
   logic [ACC_BITS-1:0]        rsp_value_ff;
   logic [COL_W-1:0]           rsp_col_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= RST_OP_MODE;
         wcfg_ff <= RST_WIN_WIDTH;
         hcfg_ff <= RST_WIN_HEIGHT;
         lcfg_ff <= RST_LINE_WIDTH;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_OP_MODE:    op_ff   <= csr_wdata[OP_BITS-1:0];
            CSR_WIN_WIDTH:  wcfg_ff <= csr_wdata[WIN_CFG_BITS-1:0];
            CSR_WIN_HEIGHT: hcfg_ff <= csr_wdata[WIN_CFG_BITS-1:0];
            CSR_LINE_WIDTH: lcfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp sizes into their legal ranges
   always_comb begin
      win_w = (wcfg_ff == '0) ? WIN_W'(1) :
              (32'(wcfg_ff) > 32'(MAX_WIN)) ? WIN_W'(MAX_WIN) : WIN_W'(wcfg_ff);
      win_h = (hcfg_ff == '0) ? WIN_W'(1) :
              (32'(hcfg_ff) > 32'(MAX_WIN)) ? WIN_W'(MAX_WIN) : WIN_W'(hcfg_ff);
      len   = (lcfg_ff == '0) ? LEN_W'(1) :
              (32'(lcfg_ff) > 32'(MAX_LINE)) ? LEN_W'(MAX_LINE) : LEN_W'(lcfg_ff);
   end

   // Pipeline moves unless a result word waits on a stalled receiver
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && pipe_en;

   // Position of the accepted pixel and the counters after it
   always_comb begin
      c_cur = req_tuser ? '0 : col_ff;
      r_cur = req_tuser ? '0 : row_ff;
      if (32'(c_cur) >= 32'(len)) begin
         c_cur = '0;
      end
      c_next   = LEN_W'(c_cur) + LEN_W'(1);
      ocol_cur = COL_W'(32'(c_next) - 32'(win_w));
      front_ctl_in.valid = accept;
      front_ctl_in.emit  = (32'(c_next) >= 32'(win_w)) &&
                           (32'(r_cur) + 32'd1 >= 32'(win_h));
      front_ctl_in.eol   = (c_next == len);
      if (c_next >= len) begin
         col_in = '0;
         row_in = (r_cur == ROW_MAX) ? r_cur : r_cur + ROW_BITS'(1);
      end else begin
         col_in = COL_W'(c_next);
         row_in = r_cur;
      end
   end

   // Hold counters; advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         front_ctl_ff <= '0;
      end else if (pipe_en) begin
         front_ctl_ff <= front_ctl_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Front payload
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         front_col_ff  <= c_cur;
         front_ocol_ff <= ocol_cur;
         front_px_ff   <= req_tdata[PIXEL_BITS-1:0];
      end
   end

   assign ch_ctl[0]  = front_ctl_ff;
   assign ch_col[0]  = front_col_ff;
   assign ch_ocol[0] = front_ocol_ff;
   assign ch_d[0]    = front_px_ff;
   assign ch_p[0]    = ACC_BITS'(front_px_ff);

   // Chain of line cells, one per stored line
   for (genvar k = 1; k <= NCELL; k++) begin : g_cell
      rwr_cell #(
         .MAX_LINE   (MAX_LINE),
         .PIXEL_BITS (PIXEL_BITS),
         .ACC_BITS   (ACC_BITS),
         .WIN_W      (WIN_W),
         .IDX        (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .op       (op_ff),
         .height   (win_h),
         .ctl_in   (ch_ctl[k-1]),
         .col_in   (ch_col[k-1]),
         .ocol_in  (ch_ocol[k-1]),
         .d_in     (ch_d[k-1]),
         .p_in     (ch_p[k-1]),
         .ctl_out  (ch_ctl[k]),
         .col_out  (ch_col[k]),
         .ocol_out (ch_ocol[k]),
         .d_out    (ch_d[k]),
         .p_out    (ch_p[k])
      );
   end

   // Reduce across the window columns
   rwr_window #(
      .MAX_WIN    (MAX_WIN),
      .PIXEL_BITS (PIXEL_BITS),
      .ACC_BITS   (ACC_BITS),
      .COL_W      (COL_W),
      .WIN_W      (WIN_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .op        (op_ff),
      .width     (win_w),
      .height    (win_h),
      .ctl_in    (ch_ctl[NCELL]),
      .ocol_in   (ch_ocol[NCELL]),
      .d_in      (ch_d[NCELL]),
      .p_in      (ch_p[NCELL]),
      .ctl_out   (win_ctl),
      .ocol_out  (win_ocol),
      .value_out (win_value)
   );

   // Result register: load when moving, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= win_ctl.valid && win_ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_value_ff <= win_value;
         rsp_col_ff   <= win_ocol;
         rsp_last_ff  <= win_ctl.eol;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   if (PAD_BITS > 0) begin : g_pad
      assign rsp_tdata = {{PAD_BITS{1'b0}}, rsp_col_ff, rsp_value_ff};
   end else begin : g_nopad
      assign rsp_tdata = {rsp_col_ff, rsp_value_ff};
   end

   // A stall freezes the front stage
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(front_ctl_ff))
      else $error("front stage moved during a stall");

   // A new result word only comes from an emitting window word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(win_ctl.valid && win_ctl.emit))
      else $error("result word without a window word behind it");

   // Start of frame places the pixel at column zero
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> front_col_ff == '0)
      else $error("start of frame not at column zero");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of rect_window_reduce_core: sliding window sum, max and min.
// Depends on rwr_pkg and the core; a scoreboard class predicts each result word.

class window_scoreboard;
   typedef struct {
      logic signed [25:0] value;
      logic [10:0]        col;
      bit                 eol;
   } window_result_type;

   window_result_type pending_results[$];
   int             errors;
   logic [1:0]     op;
   logic [5:0]     win_w;
   logic [5:0]     win_h;
   logic [11:0]    line_len;
   int             lines[31][2048];
   longint         cells[32];
   int             col_cnt;
   int             row_cnt;
   int             phase;

   function new();
      op       = rwr_pkg::RST_OP_MODE;
      win_w    = rwr_pkg::RST_WIN_WIDTH;
      win_h    = rwr_pkg::RST_WIN_HEIGHT;
      line_len = rwr_pkg::RST_LINE_WIDTH;
      errors   = 0;
      col_cnt  = 0;
      row_cnt  = 0;
      phase    = 0;
      foreach (cells[i]) cells[i] = 0;
      foreach (lines[i, j]) lines[i][j] = 0;
   endfunction

   function int clamp(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function longint combine(longint a, longint b);
      if (op == rwr_pkg::OP_MAX) return (a > b) ? a : b;
      if (op == rwr_pkg::OP_MIN) return (a < b) ? a : b;
      return a + b;
   endfunction

   // Advance the window state by one accepted pixel word
   function void note_pixel(logic signed [15:0] px, bit sof);
      int             w;
      int             h;
      int             len;
      int             c;
      longint         colv;
      longint         acc;
      window_result_type r;
      w   = clamp(win_w, 32);
      h   = clamp(win_h, 32);
      len = clamp(line_len, 2048);
      if (sof) begin
         col_cnt = 0;
         row_cnt = 0;
         phase   = 0;
      end
      if (col_cnt >= len) col_cnt = 0;
      c = col_cnt;
      // column reduction over this pixel and the stored lines above
      colv = px;
      for (int k = 1; k < h; k++)
         colv = combine(colv, lines[(phase + 31 - k) % 31][c]);
      lines[phase][c] = px;
      for (int k = 31; k > 0; k--) cells[k] = cells[k-1];
      cells[0] = colv;
      if (c + 1 >= w && row_cnt + 1 >= h) begin
         acc = cells[0];
         for (int k = 1; k < w; k++) acc = combine(acc, cells[k]);
         r.value = acc[25:0];
         r.col   = 11'(c + 1 - w);
         r.eol   = (c + 1 == len);
         pending_results = {pending_results, r};
      end
      if (c + 1 >= len) begin
         col_cnt = 0;
         if (row_cnt < 63) row_cnt++;
         phase = (phase + 1) % 31;
      end else begin
         col_cnt = c + 1;
      end
   endfunction

   // Compare one result word with the oldest prediction
   function void check_result(logic [39:0] data, logic last);
      window_result_type r;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result word value=%0d col=%0d eol=%0b", $time,
                  $signed(data[25:0]), data[36:26], last);
         errors++;
         return;
      end
      r = pending_results.pop_front();
      if (data[25:0] !== r.value) begin
         $display("%0t: value mismatch expected %0d actual %0d", $time, r.value,
                  $signed(data[25:0]));
         errors++;
      end
      if (data[36:26] !== r.col) begin
         $display("%0t: column mismatch expected %0d actual %0d", $time, r.col,
                  data[36:26]);
         errors++;
      end
      if (last !== r.eol) begin
         $display("%0t: end_of_line mismatch expected %0b actual %0b", $time, r.eol,
                  last);
         errors++;
      end
   endfunction
endclass

module tb
   import rwr_pkg::*;
();

   localparam int         LATENCY   = 50;
   localparam int         WDOG_MAX  = 5000;
   localparam int         ITEM_GOAL = 1550;
   localparam int         QUIET_AT  = 1400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   window_scoreboard sb = new();
   int  sent_count = 0;
   int  idle_cycles = 0;
   bit  quiet;

   logic signed [15:0] edge_pixels[8] = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1,
                                         16'sd1, 16'sh5555, 16'shAAAA, 16'sd1234};

   assign quiet = (sent_count >= QUIET_AT);

   rect_window_reduce_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Note accepted words on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_pixel(req_tdata, req_tuser);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Stall the result side in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Drive one pixel word, at times with a random gap ahead of it
   task automatic push_pixel(logic signed [15:0] px, bit sof);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Hold the sender until every expected word has arrived, then drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Write all four registers while the core is idle
   task automatic set_window(logic [1:0] op, logic [5:0] w, logic [5:0] h,
                             logic [11:0] len);
      wait_idle();
      csr_we <= 1'b1;
      csr_addr <= CSR_OP_MODE;    csr_wdata <= CSR_DATA_BITS'(op); @(posedge clock);
      csr_addr <= CSR_WIN_WIDTH;  csr_wdata <= CSR_DATA_BITS'(w);  @(posedge clock);
      csr_addr <= CSR_WIN_HEIGHT; csr_wdata <= CSR_DATA_BITS'(h);  @(posedge clock);
      csr_addr <= CSR_LINE_WIDTH; csr_wdata <= len; @(posedge clock);
      csr_we <= 1'b0;
      sb.op = op;
      sb.win_w = w;
      sb.win_h = h;
      sb.line_len = len;
   endtask

   initial begin
      logic [1:0]  op;
      int          w;
      int          h;
      int          len;
      int          rows;
      bit          paused;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operator over the extreme pixel values
      for (int o = 0; o < 4; o++) begin
         set_window(o[1:0], 6'd2, 6'd2, 12'd3);
         for (int i = 0; i < 6; i++) push_pixel(edge_pixels[(i + o) % 8], i == 0);
      end

      // Zero sizes act as one; run past the row counter saturation
      set_window(OP_MAX, 6'd0, 6'd0, 12'd0);
      for (int i = 0; i < 70; i++) push_pixel(edge_pixels[i % 8], i == 0);

      // Oversized line clamps to the maximum line; partial frame only
      set_window(OP_MIN, 6'd1, 6'd1, 12'd4095);
      for (int i = 0; i < 100; i++) push_pixel(16'($urandom), i == 0);

      // Largest window, all pixels at the negative extreme: most negative sum
      set_window(OP_SUM, 6'd63, 6'd40, 12'd32);
      for (int i = 0; i < 32 * 32; i++) push_pixel(-16'sd32768, i == 0);

      // Random frames with random content and the odd broken frame
      paused = 0;
      while (sent_count < ITEM_GOAL) begin
         op  = 2'($urandom_range(0, 3));
         w   = $urandom_range(1, 6);
         h   = $urandom_range(1, 6);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(w, 12);
         set_window(op, 6'(w), 6'(h), 12'(len));
         rows = $urandom_range(h, h + 4);
         for (int i = 0; i < rows * len; i++) begin
            if (!paused && i == 5) begin
               wait_idle();
               paused = 1;
            end
            if ($urandom_range(0, 7) == 0)
               push_pixel(edge_pixels[$urandom_range(0, 7)],
                          i == 0 || $urandom_range(0, 99) == 0);
            else
               push_pixel(16'($urandom), i == 0 || $urandom_range(0, 99) == 0);
         end
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

@@ rect_window_reduce_core.f @@
rtl/core/rwr_pkg.sv
rtl/core/rwr_cell.sv
rtl/core/rwr_window.sv
rtl/core/rect_window_reduce_core.sv
tb/tb.sv
